[design/vru_pkg.sv]
package vru_pkg;

    // fixed field formats
    localparam int VEC_WIDTH     = 16;
    localparam int VEC_FRAC_BITS = 14;
    localparam int IOR_WIDTH     = 16;
    localparam int IOR_FRAC      = 13;

    localparam int IN_WIDTH  = 6 * VEC_WIDTH + IOR_WIDTH;
    localparam int OUT_WIDTH = 3 * VEC_WIDTH;

    // internal widths, sized from the value ranges of the datapath
    localparam int DPW  = 18;  // one term of the dot product, signed
    localparam int CW   = 18;  // |cosi|
    localparam int KW   = 23;  // 1 - cosi^2, signed
    localparam int QW   = 28;  // eta, unsigned
    localparam int RW   = 17;  // divider remainder
    localparam int E2W  = 41;  // eta^2
    localparam int ECW  = 31;  // eta * cosi
    localparam int PLW  = 44;  // partial product, low half of eta^2
    localparam int PHW  = 45;  // partial product, high half of eta^2
    localparam int MW   = 50;  // eta^2 * k, signed
    localparam int SQW  = 64;  // root unit working width
    localparam int RTW  = 31;  // root
    localparam int COW  = 33;  // coefficient on the normal, signed
    localparam int AW   = 31;  // v * eta term, signed
    localparam int BW   = 35;  // n * coef term, signed
    localparam int SW   = 36;  // sum before output saturation

    localparam int E2_SPLIT  = 20;
    localparam int DIV_STEPS = 4;
    localparam int SQ_STEPS  = 32;

    // stage numbers
    localparam int ST_DIV_LAST = 7;
    localparam int ST_ETA      = 8;
    localparam int ST_PART     = 9;
    localparam int ST_MERGE    = 10;
    localparam int ST_COST     = 11;
    localparam int ST_SQ_FIRST = 12;
    localparam int ST_SQ_LAST  = ST_SQ_FIRST + SQ_STEPS - 1;
    localparam int ST_COEF     = ST_SQ_LAST + 1;
    localparam int ST_PROD     = ST_COEF + 1;
    localparam int ST_OUT      = ST_PROD + 1;
    localparam int NUM_STAGES  = ST_OUT;

    localparam logic signed [KW:0] ONE_Q = (KW + 1)'(1 << VEC_FRAC_BITS);

    typedef struct packed {
        logic [2:0][VEC_WIDTH-1:0] v;
        logic [2:0][VEC_WIDTH-1:0] n;
        logic [IOR_WIDTH-1:0]      r;
        logic [2:0][DPW-1:0]       dp;
        logic [CW-1:0]             cosi;
        logic                      back;
        logic [KW-1:0]             k;
        logic [QW-1:0]             q;
        logic [RW-1:0]             drem;
        logic [QW-1:0]             eta;
        logic [E2W-1:0]            eta2;
        logic [ECW-1:0]            ec;
        logic [PLW-1:0]            pl;
        logic [PHW-1:0]            ph;
        logic [MW-1:0]             m;
        logic                      tir;
        logic [SQW-1:0]            sq_x;
        logic [SQW-1:0]            sq_res;
        logic [COW-1:0]            coef;
        logic [2:0][AW-1:0]        a;
        logic [2:0][BW-1:0]        b;
        logic [2:0][VEC_WIDTH-1:0] o;
    } pipe_t;

    typedef struct packed {
        logic [QW-1:0] q;
        logic [RW-1:0] rem;
    } div_t;

    typedef struct packed {
        logic [SQW-1:0] x;
        logic [SQW-1:0] res;
    } sq_t;

    // product shifted down by the fraction bits, truncated toward zero
    function automatic logic signed [71:0] trunc_q(input logic signed [71:0] p);
        logic signed [71:0] mag;
        mag = (p < 0) ? -p : p;
        mag = mag >>> VEC_FRAC_BITS;
        return (p < 0) ? -mag : mag;
    endfunction

    // four restoring division steps of 2^27 / r
    function automatic div_t div_steps(input div_t d, input logic [IOR_WIDTH-1:0] r,
                                       input int base);
        div_t         t;
        logic [RW-1:0] sh;
        logic [4:0]   pos;
        t = d;
        for (int j = 0; j < DIV_STEPS; j++) begin
            sh  = {t.rem[RW-2:0], 1'((base + j) == 0)};
            pos = 5'(QW - 1 - base - j);
            if (sh >= {1'b0, r}) begin
                sh         = sh - {1'b0, r};
                t.q[pos]   = 1'b1;
            end
            t.rem = sh;
        end
        return t;
    endfunction

    // one digit of the integer square root
    function automatic sq_t sq_step(input sq_t s, input int i);
        sq_t            t;
        logic [SQW-1:0] bitv;
        logic [SQW-1:0] trial;
        t     = s;
        bitv  = SQW'(1) << (62 - 2 * i);
        trial = t.res + bitv;
        if (t.x >= trial) begin
            t.x   = t.x - trial;
            t.res = (t.res >> 1) + bitv;
        end
        else begin
            t.res = t.res >> 1;
        end
        return t;
    endfunction

    function automatic logic [VEC_WIDTH-1:0] sat_vec(input logic signed [SW-1:0] s);
        localparam logic signed [SW-1:0] HI = SW'((1 << (VEC_WIDTH - 1)) - 1);
        localparam logic signed [SW-1:0] LO = -HI - SW'(1);
        logic signed [SW-1:0] c;
        c = s;
        if (c > HI) c = HI;
        if (c < LO) c = LO;
        return c[VEC_WIDTH-1:0];
    endfunction

endpackage

[design/vector_refraction_unit.sv]
// Vector refraction unit: Snell's-law refraction of a direction at a surface.
//
// Input channel s_axis_*: one transfer carries the incident direction, the
// unit surface normal (both signed Q2.14) and the index of refraction
// (unsigned Q3.13). Output channel m_axis_*: one transfer per input with the
// refracted direction (Q2.14, saturated) in tdata and the total internal
// reflection flag in tuser; on that flag the direction is zero.
//
// 46 register stages. Throughput is one transfer per cycle while the output is
// not stalled (see below). The depth is set by the 2^27 / index divider
// (seven stages of four bits), the 32 digit stages of the square root of the
// cosine term and the split eta^2 * (1 - cos^2) multiply.
//
// All stages move together on a single enable. When the receiver drops
// m_axis_tready while the last stage holds a result, the whole pipeline holds
// and s_axis_tready falls in the same cycle; empty slots hold as well, so
// bubbles are not squeezed out. Nothing is lost or repeated.
//
// Reset (rst_n low, asynchronous) clears the valid bits of every stage; the
// block keeps no other state between items.
module vector_refraction_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // in_x, in_y, in_z, norm_x, norm_y, norm_z, index_ratio
    input  logic [vru_pkg::IN_WIDTH-1:0]   s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_x, out_y, out_z
    output logic [vru_pkg::OUT_WIDTH-1:0]  m_axis_tdata,
    // total_internal
    output logic [0:0]                     m_axis_tuser
);

    localparam int NST = vru_pkg::NUM_STAGES;
    localparam int VW  = vru_pkg::VEC_WIDTH;

    vru_pkg::pipe_t pipe_in;
    vru_pkg::pipe_t pipe_src  [1:NST];
    vru_pkg::pipe_t pipe_next [1:NST];
    vru_pkg::pipe_t pipe_reg  [1:NST];
    logic           valid_src [1:NST];
    logic           valid_reg [1:NST];
    logic           en;

    // whole pipeline advances unless a finished result is stuck at the output
    assign en            = !valid_reg[NST] || m_axis_tready;
    assign s_axis_tready = en;

    always_comb
    begin
        pipe_in   = '0;
        pipe_in.v = s_axis_tdata[3*VW-1:0];
        pipe_in.n = s_axis_tdata[6*VW-1:3*VW];
        pipe_in.r = s_axis_tdata[vru_pkg::IN_WIDTH-1:6*VW];
    end

    assign pipe_src[1]  = pipe_in;
    assign valid_src[1] = s_axis_tvalid;

    genvar gs;
    generate
        for (gs = 2; gs <= NST; gs++)
        begin : g_src
            assign pipe_src[gs]  = pipe_reg[gs-1];
            assign valid_src[gs] = valid_reg[gs-1];
        end

        for (gs = 1; gs <= NST; gs++)
        begin : g_stage
            always_comb
            begin
                vru_pkg::pipe_t          t;
                vru_pkg::div_t           d;
                vru_pkg::sq_t            sq;
                logic signed [31:0]      pvn;
                logic signed [19:0]      dot;
                logic [2*vru_pkg::CW-1:0] cc;
                logic [55:0]             ee;
                logic [47:0]             ecp;
                logic signed [64:0]      p;
                logic signed [vru_pkg::MW:0] cost;
                logic signed [vru_pkg::COW-1:0] cf;
                logic signed [44:0]      pa;
                logic signed [48:0]      pb;
                logic signed [vru_pkg::SW-1:0] s;

                t    = pipe_src[gs];
                d    = '0;
                sq   = '0;
                pvn  = '0;
                dot  = '0;
                cc   = '0;
                ee   = '0;
                ecp  = '0;
                p    = '0;
                cost = '0;
                cf   = '0;
                pa   = '0;
                pb   = '0;
                s    = '0;

                // 2^27 / index, four quotient bits per stage
                if (gs <= vru_pkg::ST_DIV_LAST)
                begin
                    if (gs == 1)
                    begin
                        t.q    = '0;
                        t.drem = '0;
                        if (t.r == '0) t.r = vru_pkg::IOR_WIDTH'(1);
                    end
                    d.q   = t.q;
                    d.rem = t.drem;
                    d     = vru_pkg::div_steps(d, t.r, (gs - 1) * vru_pkg::DIV_STEPS);
                    t.q    = d.q;
                    t.drem = d.rem;
                end

                if (gs == 1)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        pvn     = $signed(t.v[i]) * $signed(t.n[i]);
                        t.dp[i] = vru_pkg::DPW'(vru_pkg::trunc_q(72'(pvn)));
                    end
                end
                else if (gs == 2)
                begin
                    // cosi = -dot, taken as |dot|; a positive dot means the back side
                    dot = 20'($signed(t.dp[0])) + 20'($signed(t.dp[1]))
                        + 20'($signed(t.dp[2]));
                    t.back = (dot > 0);
                    t.cosi = t.back ? vru_pkg::CW'(dot) : vru_pkg::CW'(-dot);
                end
                else if (gs == 3)
                begin
                    cc  = t.cosi * t.cosi;
                    t.k = vru_pkg::KW'(vru_pkg::ONE_Q
                        - $signed({1'b0, cc[2*vru_pkg::CW-1:vru_pkg::VEC_FRAC_BITS]}));
                end
                else if (gs == vru_pkg::ST_ETA)
                begin
                    t.eta  = t.back ? vru_pkg::QW'({t.r, 1'b0}) : t.q;
                    ee     = t.eta * t.eta;
                    t.eta2 = vru_pkg::E2W'(ee >> vru_pkg::VEC_FRAC_BITS);
                    ecp    = 48'(t.eta) * 48'(t.cosi);
                    t.ec   = vru_pkg::ECW'(ecp >> vru_pkg::VEC_FRAC_BITS);
                end
                else if (gs == vru_pkg::ST_PART)
                begin
                    t.pl = vru_pkg::PLW'($signed({1'b0, t.eta2[vru_pkg::E2_SPLIT-1:0]})
                         * $signed(t.k));
                    t.ph = vru_pkg::PHW'(
                        $signed({1'b0, t.eta2[vru_pkg::E2W-1:vru_pkg::E2_SPLIT]})
                        * $signed(t.k));
                end
                else if (gs == vru_pkg::ST_MERGE)
                begin
                    p   = (65'($signed(t.ph)) <<< vru_pkg::E2_SPLIT) + 65'($signed(t.pl));
                    t.m = vru_pkg::MW'(vru_pkg::trunc_q(72'(p)));
                end
                else if (gs == vru_pkg::ST_COST)
                begin
                    cost     = (vru_pkg::MW + 1)'(vru_pkg::ONE_Q)
                             - (vru_pkg::MW + 1)'($signed(t.m));
                    t.tir    = (cost < 0);
                    t.sq_res = '0;
                    t.sq_x   = t.tir ? '0
                             : (vru_pkg::SQW'(cost) << vru_pkg::VEC_FRAC_BITS);
                end
                else if (gs >= vru_pkg::ST_SQ_FIRST && gs <= vru_pkg::ST_SQ_LAST)
                begin
                    sq.x     = t.sq_x;
                    sq.res   = t.sq_res;
                    sq       = vru_pkg::sq_step(sq, gs - vru_pkg::ST_SQ_FIRST);
                    t.sq_x   = sq.x;
                    t.sq_res = sq.res;
                end
                else if (gs == vru_pkg::ST_COEF)
                begin
                    // flipping the normal is folded into the coefficient
                    cf = $signed({2'b00, t.ec})
                       - $signed({2'b00, t.sq_res[vru_pkg::RTW-1:0]});
                    t.coef = t.back ? -cf : cf;
                end
                else if (gs == vru_pkg::ST_PROD)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        pa = $signed(t.v[i]) * $signed({1'b0, t.eta});
                        pb = $signed(t.n[i]) * $signed(t.coef);
                        t.a[i] = vru_pkg::AW'(vru_pkg::trunc_q(72'(pa)));
                        t.b[i] = vru_pkg::BW'(vru_pkg::trunc_q(72'(pb)));
                    end
                end
                else if (gs == vru_pkg::ST_OUT)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        s = vru_pkg::SW'($signed(t.a[i])) + vru_pkg::SW'($signed(t.b[i]));
                        t.o[i] = t.tir ? '0 : vru_pkg::sat_vec(s);
                    end
                end

                pipe_next[gs] = t;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[gs] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[gs] <= valid_src[gs];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pipe_reg[gs] <= pipe_next[gs];
                end
            end
        end
    endgenerate

    assign m_axis_tvalid   = valid_reg[NST];
    assign m_axis_tdata    = pipe_reg[NST].o;
    assign m_axis_tuser[0] = pipe_reg[NST].tir;

endmodule

[sim/tb_vector_refraction_unit.sv]
module tb_vector_refraction_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VEC_WIDTH     = vru_pkg::VEC_WIDTH;
    localparam int VEC_FRAC_BITS = vru_pkg::VEC_FRAC_BITS;
    localparam int IOR_WIDTH     = vru_pkg::IOR_WIDTH;
    localparam int IOR_FRAC      = vru_pkg::IOR_FRAC;
    localparam int IN_WIDTH      = vru_pkg::IN_WIDTH;
    localparam int OUT_WIDTH     = vru_pkg::OUT_WIDTH;

    localparam int NUM_RANDOM = 1500;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 100;
    localparam longint SAT62 = 64'sh3FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [VEC_WIDTH-1:0] ox;
        logic [VEC_WIDTH-1:0] oy;
        logic [VEC_WIDTH-1:0] oz;
        logic                 tir;
    } refr_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    // in_x, in_y, in_z, norm_x, norm_y, norm_z, index_ratio (lowest first)
    logic [IN_WIDTH-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    // out_x, out_y, out_z (lowest first)
    logic [OUT_WIDTH-1:0] m_axis_tdata;
    // total_internal
    logic [0:0] m_axis_tuser;

    int errors = 0;
    int idle_cycles = 0;

    vector_refraction_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    // ---------------- refraction predictor, 64-bit saturating Q.14 ----------------
    function automatic longint sat62(input longint x);
        if (x > SAT62) return SAT62;
        if (x < -SAT62) return -SAT62;
        return x;
    endfunction

    function automatic longint add_sat(input longint a, input longint b);
        return sat62(sat62(a) + sat62(b));
    endfunction

    // exact product, shifted down with truncation toward zero, saturated
    function automatic longint mul_q14(input longint a, input longint b);
        logic [127:0] ma, mb, p;
        logic         neg;
        longint       ca, cb, r;
        ca = sat62(a);
        cb = sat62(b);
        neg = (ca < 0) != (cb < 0);
        ma = (ca < 0) ? 128'(-ca) : 128'(ca);
        mb = (cb < 0) ? 128'(-cb) : 128'(cb);
        p = (ma * mb) >> VEC_FRAC_BITS;
        if (p > 128'(SAT62)) r = SAT62;
        else r = longint'(p[63:0]);
        return neg ? -r : r;
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] res, bitv, xv;
        res = 0;
        xv = x;
        bitv = 64'd1 << 62;
        while (bitv > xv) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (xv >= res + bitv)
            begin
                xv = xv - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [VEC_WIDTH-1:0] clamp_out(input longint x);
        if (x > 32767) return 16'h7FFF;
        if (x < -32768) return 16'h8000;
        return x[VEC_WIDTH-1:0];
    endfunction

    function automatic refr_t refract(input logic [IN_WIDTH-1:0] d);
        longint      v[3], n[3];
        longint      one, dot, cosi, eta, k, cost, coef, root;
        logic [63:0] r, rad;
        refr_t       res;
        one = 64'sd1 << VEC_FRAC_BITS;
        for (int i = 0; i < 3; i++)
        begin
            v[i] = longint'($signed(d[i*VEC_WIDTH +: VEC_WIDTH]));
            n[i] = longint'($signed(d[(3+i)*VEC_WIDTH +: VEC_WIDTH]));
        end
        r = 64'(d[6*VEC_WIDTH +: IOR_WIDTH]);
        if (r == 0) r = 1;
        dot = add_sat(add_sat(mul_q14(v[0], n[0]), mul_q14(v[1], n[1])),
                      mul_q14(v[2], n[2]));
        cosi = -dot;
        eta = longint'((64'd1 << (VEC_FRAC_BITS + IOR_FRAC)) / r);
        if (cosi < 0)
        begin
            // back side: flip the normal, invert the ratio
            cosi = -cosi;
            for (int i = 0; i < 3; i++) n[i] = -n[i];
            eta = longint'((r << VEC_FRAC_BITS) >> IOR_FRAC);
        end
        k = add_sat(one, -mul_q14(cosi, cosi));
        cost = add_sat(one, -mul_q14(mul_q14(eta, eta), k));
        if (cost < 0)
        begin
            res.ox = 0;
            res.oy = 0;
            res.oz = 0;
            res.tir = 1'b1;
            return res;
        end
        if (64'(cost) > (64'hFFFF_FFFF_FFFF_FFFF >> VEC_FRAC_BITS)) rad = '1;
        else rad = 64'(cost) << VEC_FRAC_BITS;
        root = longint'(root64(rad));
        coef = add_sat(mul_q14(eta, cosi), -root);
        res.ox = clamp_out(add_sat(mul_q14(v[0], eta), mul_q14(n[0], coef)));
        res.oy = clamp_out(add_sat(mul_q14(v[1], eta), mul_q14(n[1], coef)));
        res.oz = clamp_out(add_sat(mul_q14(v[2], eta), mul_q14(n[2], coef)));
        res.tir = 1'b0;
        return res;
    endfunction

    // ---------------- scoreboard ----------------
    class refr_scoreboard;
        refr_t pending[$];

        function void note_input(input logic [IN_WIDTH-1:0] d);
            pending.push_back(refract(d));
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        task check_result(input logic [OUT_WIDTH-1:0] d, input logic tir);
            refr_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected result", longint'(d), 0);
                return;
            end
            want = pending.pop_front();
            if (d[0 +: VEC_WIDTH] !== want.ox)
                report_mismatch("out_x", d[0 +: VEC_WIDTH], want.ox);
            if (d[VEC_WIDTH +: VEC_WIDTH] !== want.oy)
                report_mismatch("out_y", d[VEC_WIDTH +: VEC_WIDTH], want.oy);
            if (d[2*VEC_WIDTH +: VEC_WIDTH] !== want.oz)
                report_mismatch("out_z", d[2*VEC_WIDTH +: VEC_WIDTH], want.oz);
            if (tir !== want.tir)
                report_mismatch("total_internal", tir, want.tir);
        endtask
    endclass

    refr_scoreboard sb;

    // ---------------- clock, reset ----------------
    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // gap length: mostly 0..2, sometimes up to 40
    function automatic int pick_gap();
        if ($urandom_range(0, 15) == 0) return $urandom_range(5, 40);
        return $urandom_range(0, 2);
    endfunction

    // monitor: every accepted transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser[0]);
        end
    end

    // watchdog on cycles with no transfer at all
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random stalls, with long runs of steady ready
    initial
    begin
        int gap;
        bit steady;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            steady = ($urandom_range(0, 7) == 0);
            gap = steady ? 0 : pick_gap();
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat (steady ? $urandom_range(50, 200) : $urandom_range(1, 6)) @(posedge clk);
        end
    end

    // one transfer; valid stays high across back-to-back items
    task automatic send_item(input logic [IN_WIDTH-1:0] d, input int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    function automatic logic [IN_WIDTH-1:0] pack_item(input logic [15:0] vx, vy, vz,
                                                      input logic [15:0] nx, ny, nz,
                                                      input logic [15:0] r);
        return {r, nz, ny, nx, vz, vy, vx};
    endfunction

    // one random direction component in -1.0..+1.0 (Q2.14)
    function automatic logic [15:0] unit_comp();
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic logic [IN_WIDTH-1:0] random_item();
        logic [15:0] c[7];
        int mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 6; i++)
            c[i] = (mode < 7) ? unit_comp() : 16'($urandom);
        // indices: in half the items 0.5..2.0 (near glass/air ratios), else anything
        if (mode < 5) c[6] = 16'($urandom_range(4096, 16384));
        else c[6] = 16'($urandom);
        if (mode == 6)
        begin
            // axis-aligned normal, grazing or head-on cases
            c[3] = '0; c[4] = '0; c[5] = ($urandom_range(0, 1)) ? 16'h4000 : 16'hC000;
        end
        return pack_item(c[0], c[1], c[2], c[3], c[4], c[5], c[6]);
    endfunction

    initial
    begin
        int cnt;
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: head-on, back side, grazing, zero index, extremes, TIR
        send_item(pack_item(16'hC000, 0, 0, 16'h4000, 0, 0, 16'h2000), 0);
        send_item(pack_item(16'h4000, 0, 0, 16'h4000, 0, 0, 16'h3000), 0);
        send_item(pack_item(0, 16'h4000, 0, 16'h4000, 0, 0, 16'h2000), 0);
        send_item(pack_item(0, 16'h4000, 0, 16'h4000, 0, 0, 16'h3000), 0);
        send_item(pack_item(16'hD2BF, 16'h2D41, 0, 0, 16'hC000, 0, 16'h0000), 0);
        send_item(pack_item(16'hD2BF, 16'h2D41, 0, 0, 16'hC000, 0, 16'h0001), 1);
        send_item(pack_item(16'hD2BF, 16'h2D41, 0, 0, 16'hC000, 0, 16'hFFFF), 0);
        send_item(pack_item(16'h2D41, 16'h2D41, 0, 0, 16'h4000, 0, 16'h3000), 0);
        send_item(pack_item(16'h2D41, 16'h2D41, 0, 0, 16'h4000, 0, 16'hFFFF), 0);
        send_item(pack_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                            16'hFFFF), 0);
        send_item(pack_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                            16'h0001), 0);
        send_item(pack_item(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                            16'h8000), 2);
        send_item(pack_item(0, 0, 0, 0, 0, 0, 16'h2000), 0);
        send_item(pack_item(16'h4000, 0, 0, 0, 0, 0, 16'h0000), 0);
        send_item(pack_item(0, 0, 16'hC000, 0, 0, 16'h4000, 16'h2AAB), 0);
        send_item(pack_item(0, 0, 16'h4000, 0, 0, 16'h4000, 16'h2AAB), 0);
        send_item(pack_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            16'hFFFF), 0);
        send_item(pack_item(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                            16'h5555), 0);
        send_item(pack_item(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                            16'hAAAA), 0);

        // hold off until the pipeline has drained completely
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);

        for (cnt = 0; cnt < NUM_RANDOM; cnt++)
            send_item(random_item(), ($urandom_range(0, 3) == 0) ? 0 : pick_gap());
        s_axis_tvalid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
